### rtl/device_heartbeat_aging_table_macros.svh
// Assertion macros used by the checker file of the heartbeat aging table.
`ifndef DEVICE_HEARTBEAT_AGING_TABLE_MACROS_SVH
`define DEVICE_HEARTBEAT_AGING_TABLE_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define DHAT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define DHAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dhat_pkg.sv
// Package of the heartbeat aging table: sizes, codes and the entry type.
package dhat_pkg;

  localparam int SLOTS = 64;
  localparam int DEPTH = 2 * SLOTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  localparam int FUNC_W = 2;
  localparam int SLOT_W = 6;
  localparam int ID_W   = 16;
  localparam int TTL_W  = 4;
  localparam int ACT_W  = 16;
  localparam int STAT_W = 3;

  localparam logic [TTL_W-1:0] TTL_RESET = 4'd2;
  localparam logic [ACT_W-1:0] ACT_MAX   = {ACT_W{1'b1}};

  // Function codes of an input item
  localparam logic [FUNC_W-1:0] FN_HEARTBEAT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_TICK      = 2'd1;
  localparam logic [FUNC_W-1:0] FN_QUERY     = 2'd2;

  // Status codes of a result item
  localparam logic [STAT_W-1:0] ST_UPDATED = 3'd0;
  localparam logic [STAT_W-1:0] ST_ADDED   = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STAT_W-1:0] ST_TICK    = 3'd3;
  localparam logic [STAT_W-1:0] ST_QUERY   = 3'd4;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [TTL_W-1:0] life;
    logic [ACT_W-1:0] act;
  } entry_t;

  // Control of the entry update unit
  typedef struct packed {
    logic             tick;
    logic [TTL_W-1:0] ttl;
    logic [ID_W-1:0]  id;
  } alu_ctl_t;

  // Flags from the entry update unit
  typedef struct packed {
    logic hit;
    logic free;
  } alu_flags_t;

endpackage

### rtl/dhat_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
module dhat_ram #(
  parameter int DW    = 36,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write one word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one word, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/dhat_alu.sv
// Entry update unit: id compare, lifetime aging and activity count.
module dhat_alu (
  input  dhat_pkg::alu_ctl_t   ctl,
  input  logic                 used,
  input  dhat_pkg::entry_t     cur,
  output dhat_pkg::entry_t     upd,
  output dhat_pkg::alu_flags_t flags
);
  import dhat_pkg::*;

  logic [TTL_W-1:0] life_dec;

  // Age the lifetime, saturating at zero
  assign life_dec = (cur.life != '0) ? cur.life - TTL_W'(1) : '0;

  // Flag a free slot or a matching id
  assign flags.free = !used;
  assign flags.hit  = used && (cur.id == ctl.id);

  // Build the next entry
  always_comb begin
    upd = cur;
    if (ctl.tick) begin
      upd.life = life_dec;
      if (life_dec == '0) begin
        upd.act = '0;
      end
    end else if (!used) begin
      upd.id   = ctl.id;
      upd.life = ctl.ttl;
      upd.act  = '0;
    end else begin
      upd.life = ctl.ttl;
      if (cur.act != ACT_MAX) begin
        upd.act = cur.act + ACT_W'(1);
      end
    end
  end

endmodule

### rtl/device_heartbeat_aging_table.sv
// Top level of the heartbeat aging table: sequencer, used bits and result register.
//
//  channel | ports                               | handshake
//  --------+-------------------------------------+-------------------------------
//  input   | in_func in_device_class in_device_id| start high, busy low
//          | in_slot                             |
//  result  | out_status out_entry_*              | out_valid, one cycle
//  config  | cfg_wdata                           | cfg_we
//
// A tick walks both tables one entry per cycle through the RAM read port.
// A heartbeat walks its table until it finds a match or a free slot, or to
// its end when the table is full. A query reads its slot (S_QRD), then
// answers (S_QAN). The result is registered and shows in the cycle after the
// last step, with busy already low. Reset clears the used bits at once; no
// clearing pass is run. The receiver cannot stall; results are never held.
module device_heartbeat_aging_table (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [dhat_pkg::FUNC_W-1:0]    in_func,
  input  logic                           in_device_class,
  input  logic [dhat_pkg::ID_W-1:0]      in_device_id,
  input  logic [dhat_pkg::SLOT_W-1:0]    in_slot,
  output logic                           out_valid,
  output logic [dhat_pkg::STAT_W-1:0]    out_status,
  output logic                           out_entry_valid,
  output logic [dhat_pkg::ID_W-1:0]      out_entry_id,
  output logic                           out_entry_alive,
  output logic [dhat_pkg::ACT_W-1:0]     out_entry_active_for,
  input  logic                           cfg_we,
  input  logic [dhat_pkg::TTL_W-1:0]     cfg_wdata
);
  import dhat_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_HB   = 5'b00010,
    S_TICK = 5'b00100,
    S_QRD  = 5'b01000,
    S_QAN  = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [TTL_W-1:0]   ttl_r;
  logic               cls_r, cls_nxt;
  logic [ID_W-1:0]    id_r, id_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               ev_r, ev_nxt;
  logic [CW-1:0]      ev_cnt_r, ev_cnt_nxt;
  logic [AW-1:0]      ev_addr_r, ev_addr_nxt;
  logic               qok_r, qok_nxt;
  logic [DEPTH-1:0]   used_r, used_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]  out_status_r, out_status_nxt;
  logic               out_entry_valid_r, out_entry_valid_nxt;
  logic [ID_W-1:0]    out_entry_id_r, out_entry_id_nxt;
  logic               out_entry_alive_r, out_entry_alive_nxt;
  logic [ACT_W-1:0]   out_entry_act_r, out_entry_act_nxt;

  logic [AW-1:0]      base;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  entry_t             rd_data;
  entry_t             upd;
  alu_ctl_t           alu_ctl;
  alu_flags_t         alu_flags;
  logic               used_e;
  logic               slot_in_range;

  assign base          = cls_r ? AW'(SLOTS) : '0;
  assign used_e        = used_r[ev_addr_r];
  assign slot_in_range = (32'(slot_r) < SLOTS);

  assign alu_ctl.tick = (state_r == S_TICK);
  assign alu_ctl.ttl  = ttl_r;
  assign alu_ctl.id   = id_r;

  dhat_ram #(
    .DW    ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (ev_addr_r),
    .wdata (upd),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  dhat_alu u_alu (
    .ctl   (alu_ctl),
    .used  (used_e),
    .cur   (rd_data),
    .upd   (upd),
    .flags (alu_flags)
  );

  // Sequence one item over the table
  always_comb begin
    state_nxt           = state_r;
    cls_nxt             = cls_r;
    id_nxt              = id_r;
    slot_nxt            = slot_r;
    cnt_nxt             = cnt_r;
    ev_nxt              = 1'b0;
    ev_cnt_nxt          = ev_cnt_r;
    ev_addr_nxt         = ev_addr_r;
    qok_nxt             = qok_r;
    used_nxt            = used_r;
    rd_addr             = '0;
    wr_en               = 1'b0;
    out_valid_nxt       = 1'b0;
    out_status_nxt      = out_status_r;
    out_entry_valid_nxt = out_entry_valid_r;
    out_entry_id_nxt    = out_entry_id_r;
    out_entry_alive_nxt = out_entry_alive_r;
    out_entry_act_nxt   = out_entry_act_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cls_nxt  = in_device_class;
          id_nxt   = in_device_id;
          slot_nxt = in_slot;
          cnt_nxt  = '0;
          case (in_func)
            FN_HEARTBEAT: state_nxt = S_HB;
            FN_TICK:      state_nxt = S_TICK;
            default:      state_nxt = S_QRD;
          endcase
        end
      end

      S_HB: begin
        // Issue the next read of this table
        rd_addr = base + AW'(cnt_r);
        if (cnt_r < CW'(SLOTS)) begin
          ev_nxt      = 1'b1;
          ev_addr_nxt = rd_addr;
          ev_cnt_nxt  = cnt_r;
          cnt_nxt     = cnt_r + CW'(1);
        end
        // Check the entry read last cycle
        if (ev_r) begin
          if (alu_flags.free || alu_flags.hit) begin
            wr_en               = 1'b1;
            used_nxt[ev_addr_r] = 1'b1;
            out_status_nxt      = alu_flags.free ? ST_ADDED : ST_UPDATED;
            out_valid_nxt       = 1'b1;
          end else if (ev_cnt_r == CW'(SLOTS - 1)) begin
            out_status_nxt = ST_FULL;
            out_valid_nxt  = 1'b1;
          end
          if (out_valid_nxt) begin
            ev_nxt              = 1'b0;
            state_nxt           = S_IDLE;
            out_entry_valid_nxt = 1'b0;
            out_entry_id_nxt    = '0;
            out_entry_alive_nxt = 1'b0;
            out_entry_act_nxt   = '0;
          end
        end
      end

      S_TICK: begin
        // Read every entry of both tables in turn
        rd_addr = AW'(cnt_r);
        if (cnt_r < CW'(DEPTH)) begin
          ev_nxt      = 1'b1;
          ev_addr_nxt = rd_addr;
          ev_cnt_nxt  = cnt_r;
          cnt_nxt     = cnt_r + CW'(1);
        end
        // Write back the aged entry
        if (ev_r) begin
          wr_en = used_e;
          if (ev_cnt_r == CW'(DEPTH - 1)) begin
            ev_nxt              = 1'b0;
            state_nxt           = S_IDLE;
            out_valid_nxt       = 1'b1;
            out_status_nxt      = ST_TICK;
            out_entry_valid_nxt = 1'b0;
            out_entry_id_nxt    = '0;
            out_entry_alive_nxt = 1'b0;
            out_entry_act_nxt   = '0;
          end
        end
      end

      S_QRD: begin
        rd_addr     = slot_in_range ? base + AW'(slot_r) : '0;
        ev_addr_nxt = rd_addr;
        qok_nxt     = slot_in_range;
        state_nxt   = S_QAN;
      end

      S_QAN: begin
        state_nxt      = S_IDLE;
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_QUERY;
        if (qok_r && used_e) begin
          out_entry_valid_nxt = 1'b1;
          out_entry_id_nxt    = rd_data.id;
          out_entry_alive_nxt = (rd_data.life != '0);
          out_entry_act_nxt   = rd_data.act;
        end else begin
          out_entry_valid_nxt = 1'b0;
          out_entry_id_nxt    = '0;
          out_entry_alive_nxt = 1'b0;
          out_entry_act_nxt   = '0;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ev_r        <= 1'b0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      ttl_r       <= TTL_RESET;
    end else begin
      state_r     <= state_nxt;
      ev_r        <= ev_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        ttl_r <= cfg_wdata;
      end
    end
  end

  // Hold item fields, counters and the result
  always_ff @(posedge clk) begin
    cls_r             <= cls_nxt;
    id_r              <= id_nxt;
    slot_r            <= slot_nxt;
    cnt_r             <= cnt_nxt;
    ev_cnt_r          <= ev_cnt_nxt;
    ev_addr_r         <= ev_addr_nxt;
    qok_r             <= qok_nxt;
    out_status_r      <= out_status_nxt;
    out_entry_valid_r <= out_entry_valid_nxt;
    out_entry_id_r    <= out_entry_id_nxt;
    out_entry_alive_r <= out_entry_alive_nxt;
    out_entry_act_r   <= out_entry_act_nxt;
  end

  assign busy                 = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_entry_valid      = out_entry_valid_r;
  assign out_entry_id         = out_entry_id_r;
  assign out_entry_alive      = out_entry_alive_r;
  assign out_entry_active_for = out_entry_act_r;

endmodule

### rtl/dhat_chk.sv
// Port checker of the heartbeat aging table and its bind.
`include "device_heartbeat_aging_table_macros.svh"

module dhat_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic [dhat_pkg::STAT_W-1:0] out_status,
  input logic                        out_entry_valid,
  input logic [dhat_pkg::ID_W-1:0]   out_entry_id,
  input logic                        out_entry_alive,
  input logic [dhat_pkg::ACT_W-1:0]  out_entry_active_for
);
  import dhat_pkg::*;

  logic accept;
  logic no_entry;

  assign accept   = start && !busy;
  assign no_entry = !out_entry_valid && (out_entry_id == '0) && !out_entry_alive &&
                    (out_entry_active_for == '0);

  // A result ends the item, so the block is free in that cycle
  `DHAT_ASSERT_SAME(a_result_frees, clk, rst_n, out_valid, !busy, "result while busy")
  // An accepted item makes the block busy and gives no result at once
  `DHAT_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy && !out_valid, "accept not busy")
  // Only a query answer carries entry fields
  `DHAT_ASSERT_SAME(a_entry_zero, clk, rst_n, out_valid && (out_status != ST_QUERY),
                    no_entry, "entry fields on non-query result")
  // An invalid entry shows no contents
  `DHAT_ASSERT_SAME(a_invalid_empty, clk, rst_n, out_valid && !out_entry_valid,
                    no_entry, "invalid entry with contents")

endmodule

bind device_heartbeat_aging_table dhat_chk u_dhat_chk (
  .clk                  (clk),
  .rst_n                (rst_n),
  .start                (start),
  .busy                 (busy),
  .out_valid            (out_valid),
  .out_status           (out_status),
  .out_entry_valid      (out_entry_valid),
  .out_entry_id         (out_entry_id),
  .out_entry_alive      (out_entry_alive),
  .out_entry_active_for (out_entry_active_for)
);
